// ===== hdl/mtg_pkg.sv =====
// Package for the MT19937 word generator: word and index types, algorithm constants,
// and the LCG seeding, twist and tempering functions.
// No dependencies; imported by mtg_word_ram and mersenne_twister_generator_unit.
`default_nettype none

package mtg_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned WORD_COUNT   = 624;
    localparam int unsigned SHIFT_OFFSET = 397;
    localparam int unsigned IDX_W        = 10;
    localparam int unsigned HALF_W       = WORD_W / 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [HALF_W-1:0] half_t;

    localparam word_t TWIST_MATRIX = 32'h9908_b0df;
    localparam word_t HIGH_BIT     = 32'h8000_0000;
    localparam word_t LOW_BITS     = 32'h7fff_ffff;
    localparam word_t TEMPER_B     = 32'h9d2c_5680;
    localparam word_t TEMPER_C     = 32'hefc6_0000;
    localparam word_t LCG_MULT     = 32'd69069;
    localparam word_t SEED_RESET   = 32'd4357;

    localparam idx_t LAST_IDX = idx_t'(WORD_COUNT - 1);
    localparam idx_t FAR_WRAP = idx_t'(WORD_COUNT - SHIFT_OFFSET);
    localparam idx_t FAR_STEP = idx_t'(SHIFT_OFFSET);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED_HI,
        ST_SEED_LO
    } seq_state_t;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        word_t data;
    } ram_wr_t;

    typedef struct packed {
        logic en;
        idx_t addr_a;
        idx_t addr_b;
    } ram_rd_t;

    function automatic word_t lcg_next(input word_t x);
        logic [2*WORD_W-1:0] prod;
        prod = x * LCG_MULT;
        return prod[WORD_W-1:0] + word_t'(1);
    endfunction

    function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
        word_t y;
        word_t v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    function automatic word_t temper(input word_t x);
        word_t y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic idx_t next_idx(input idx_t i);
        return (i == LAST_IDX) ? idx_t'(0) : i + idx_t'(1);
    endfunction

    function automatic idx_t far_idx(input idx_t i);
        return (i >= FAR_WRAP) ? i - FAR_WRAP : i + FAR_STEP;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mtg_word_ram.sv =====
// State word memory of the generator: 624 words, one write port, two registered read
// ports. Depends on mtg_pkg.
`default_nettype none

module mtg_word_ram
    import mtg_pkg::*;
(
    input  wire logic    aclk,
    input  wire ram_wr_t wr,
    input  wire ram_rd_t rd,
    output logic  [WORD_W-1:0] rd_a_data,
    output logic  [WORD_W-1:0] rd_b_data
);

    word_t mem [WORD_COUNT];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_a_data <= mem[rd.addr_a];
            rd_b_data <= mem[rd.addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mersenne_twister_generator_unit.sv =====
// Top level of the MT19937 word generator: request and result streams, seed register,
// seeding sequencer and the twist/temper stage. Depends on mtg_pkg and mtg_word_ram.
//
// Each request transaction returns one tempered 32-bit word. Words are twisted one at a
// time as they are drawn, so a normal request is accepted every cycle while the result
// stream is not stalled; its word is read from the state memory, then twisted, tempered
// and registered on m_tdata. A request with reseed set, and the first request after reset,
// first refill all 624 state words from the seed register through the LCG multiplier, each
// word from the upper halves of two LCG steps; no other request is taken meanwhile.
`default_nettype none

module mersenne_twister_generator_unit
    import mtg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Seed register write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] reseed, [7:1] zero
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] random_word
);

    seq_state_t state_reg;
    seq_state_t state_next;

    word_t seed_value_reg;
    logic  seeded_reg;
    idx_t  idx_reg;
    idx_t  fill_reg;
    word_t lcg_reg;
    half_t hi_reg;
    word_t cur_reg;
    logic  p1_valid_reg;
    idx_t  p1_idx_reg;
    logic  m_tvalid_reg;
    word_t m_tdata_reg;

    logic    out_ok;
    logic    p1_adv;
    logic    in_acc;
    logic    need_seed;
    logic    seed_done;
    logic    issue;
    idx_t    issue_idx;
    word_t   seed_word;
    word_t   twist_val;
    word_t   rd_a_data;
    word_t   rd_b_data;
    ram_wr_t ram_wr;
    ram_rd_t ram_rd;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign out_ok    = !m_tvalid_reg || m_tready;
    assign p1_adv    = p1_valid_reg && out_ok;
    assign s_tready  = (state_reg == ST_IDLE) && (!p1_valid_reg || out_ok);
    assign in_acc    = s_tvalid && s_tready;
    assign need_seed = s_tdata[0] || !seeded_reg;
    assign seed_done = (state_reg == ST_SEED_LO) && (fill_reg == LAST_IDX);
    assign issue     = (in_acc && !need_seed) || seed_done;
    assign issue_idx = seed_done ? idx_t'(0) : idx_reg;
    assign seed_word = {hi_reg, lcg_reg[WORD_W-1:HALF_W]};
    assign twist_val = twist_word(cur_reg, rd_a_data, rd_b_data);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && need_seed) begin
                    state_next = ST_SEED_HI;
                end
            end
            ST_SEED_HI: begin
                state_next = ST_SEED_LO;
            end
            ST_SEED_LO: begin
                state_next = (fill_reg == LAST_IDX) ? ST_IDLE : ST_SEED_HI;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_rd.en     = issue;
        ram_rd.addr_a = next_idx(issue_idx);
        ram_rd.addr_b = far_idx(issue_idx);
        ram_wr.en     = 1'b0;
        ram_wr.addr   = p1_idx_reg;
        ram_wr.data   = twist_val;
        case (state_reg)
            ST_SEED_LO: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = fill_reg;
                ram_wr.data = seed_word;
            end
            default: begin
                ram_wr.en = p1_adv;
            end
        endcase
    end

    mtg_word_ram u_word_ram (
        .aclk      (aclk),
        .wr        (ram_wr),
        .rd        (ram_rd),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seed_value_reg <= SEED_RESET;
            seeded_reg     <= 1'b0;
            idx_reg        <= '0;
            p1_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                seed_value_reg <= cfg_data;
            end
            if (seed_done) begin
                seeded_reg <= 1'b1;
            end
            if (issue) begin
                idx_reg      <= next_idx(issue_idx);
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && need_seed) begin
            lcg_reg  <= seed_value_reg;
            fill_reg <= '0;
        end else if (state_reg == ST_SEED_HI) begin
            hi_reg  <= lcg_reg[WORD_W-1:HALF_W];
            lcg_reg <= lcg_next(lcg_reg);
        end else if (state_reg == ST_SEED_LO) begin
            lcg_reg  <= lcg_next(lcg_reg);
            fill_reg <= fill_reg + idx_t'(1);
        end
        if ((state_reg == ST_SEED_LO) && (fill_reg == '0)) begin
            cur_reg <= seed_word;
        end else if (p1_adv) begin
            cur_reg <= rd_a_data;
        end
        if (issue) begin
            p1_idx_reg <= issue_idx;
        end
        if (p1_adv) begin
            m_tdata_reg <= temper(twist_val);
        end
    end

    a_single_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !((state_reg == ST_SEED_LO) && p1_adv))
        else $error("seed fill and twist write collide on the memory write port");

    a_seed_issues_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_done |=> (p1_valid_reg && (p1_idx_reg == '0) && (idx_reg == idx_t'(1))))
        else $error("draw after seeding did not start at word zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !out_ok) |=> (p1_valid_reg && $stable(p1_idx_reg)
                                      && $stable(rd_a_data) && $stable(rd_b_data)))
        else $error("stalled twist stage lost its operands");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg <= LAST_IDX) && (p1_idx_reg <= LAST_IDX || !p1_valid_reg))
        else $error("read index out of range");

    a_seed_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (!s_tready && !p1_adv))
        else $error("request or twist active during seed fill");

endmodule

`default_nettype wire
